>>> hdl/ggfb_pkg.sv
// ----------------------------------------------------------------------------
// ggfb_pkg
// Shared types, constants and the CRC-16 step function of the gripper move
// command frame builder.
// ----------------------------------------------------------------------------
package ggfb_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int FIELD_W       = 17;
	localparam int FRAME_LEN     = 15;
	localparam int CRC_SPAN      = 13;
	localparam int QDEPTH        = 2;
	localparam int QPTR_W        = $clog2(QDEPTH);
	localparam int QCNT_W        = $clog2(QDEPTH + 1);

	localparam logic [7:0]  ADDR_RESET = 8'd9;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	localparam logic [3:0] POS_ADDR     = 4'd0;
	localparam logic [3:0] POS_FUNC     = 4'd1;
	localparam logic [3:0] POS_REG_HI   = 4'd2;
	localparam logic [3:0] POS_REG_LO   = 4'd3;
	localparam logic [3:0] POS_CNT_HI   = 4'd4;
	localparam logic [3:0] POS_CNT_LO   = 4'd5;
	localparam logic [3:0] POS_BCOUNT   = 4'd6;
	localparam logic [3:0] POS_ACTION   = 4'd7;
	localparam logic [3:0] POS_ZERO_A   = 4'd8;
	localparam logic [3:0] POS_ZERO_B   = 4'd9;
	localparam logic [3:0] POS_POSITION = 4'd10;
	localparam logic [3:0] POS_SPEED    = 4'd11;
	localparam logic [3:0] POS_FORCE    = 4'd12;
	localparam logic [3:0] POS_CRC_LO   = 4'd13;
	localparam logic [3:0] POS_CRC_HI   = 4'd14;

	localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
	localparam logic [7:0] START_REG_HI     = 8'h03;
	localparam logic [7:0] START_REG_LO     = 8'hE8;
	localparam logic [7:0] REG_COUNT        = 8'h03;
	localparam logic [7:0] BYTE_COUNT       = 8'h06;
	localparam logic [7:0] ACTION_GOTO      = 8'h09;

	typedef struct packed {
		logic [7:0] position_byte;
		logic [7:0] speed_byte;
		logic [7:0] force_byte;
	} payload_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/ggfb_front.sv
// ----------------------------------------------------------------------------
// ggfb_front
// Takes move commands, saturates each fraction to 1.0 and scales it to a
// byte (the position byte from one minus the width), then hands the three payload bytes to the command queue.
// ----------------------------------------------------------------------------
module ggfb_front #(
	parameter int FRAC_BITS = ggfb_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ggfb_pkg::FIELD_W-1:0] force_frac,
	input  logic [ggfb_pkg::FIELD_W-1:0] width_frac,
	input  logic [ggfb_pkg::FIELD_W-1:0] speed_frac,
	output logic                        push,
	output ggfb_pkg::payload_t          push_data,
	input  logic                        q_full
);
	import ggfb_pkg::*;

	localparam int EW = (FRAC_BITS + 1 > FIELD_W) ? FRAC_BITS + 1 : FIELD_W;
	localparam int PW = EW + 8;
	localparam logic [EW-1:0] ONE = EW'(1) << FRAC_BITS;

	logic          valid_s1;
	payload_t      data_s1;
	logic          accept;
	logic [EW-1:0] force_c, width_c, speed_c, open_c;
	logic [PW-1:0] force_p, speed_p, pos_p;

	always_comb begin
		force_c = (EW'(force_frac) > ONE) ? ONE : EW'(force_frac);
		width_c = (EW'(width_frac) > ONE) ? ONE : EW'(width_frac);
		speed_c = (EW'(speed_frac) > ONE) ? ONE : EW'(speed_frac);
		open_c  = ONE - width_c;
		force_p = (PW'(force_c) << 8) - PW'(force_c);
		speed_p = (PW'(speed_c) << 8) - PW'(speed_c);
		pos_p   = (PW'(open_c) << 8) - PW'(open_c);
	end

	assign push      = valid_s1 && !q_full;
	assign push_data = data_s1;
	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.position_byte <= pos_p[FRAC_BITS+7:FRAC_BITS];
			data_s1.speed_byte    <= speed_p[FRAC_BITS+7:FRAC_BITS];
			data_s1.force_byte    <= force_p[FRAC_BITS+7:FRAC_BITS];
		end
	end

endmodule

>>> hdl/ggfb_queue.sv
// ----------------------------------------------------------------------------
// ggfb_queue
// Short queue of payload bytes between the command front end and the frame
// sequencer.
// ----------------------------------------------------------------------------
module ggfb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ggfb_pkg::payload_t push_data,
	input  logic               pop,
	output logic               q_valid,
	output logic               q_full,
	output ggfb_pkg::payload_t head
);
	import ggfb_pkg::*;

	payload_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == QCNT_W'(QDEPTH));
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("Queue written while full.");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("Queue read while empty.");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("Queue count exceeds its depth.");

endmodule

>>> hdl/ggfb_back.sv
// ----------------------------------------------------------------------------
// ggfb_back
// Frame sequencer: walks the fifteen frame bytes of the command at the queue
// head, folds bytes 0 to 12 into the CRC and appends the CRC, low byte first.
// ----------------------------------------------------------------------------
module ggfb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         device_address,
	input  logic               q_valid,
	input  ggfb_pkg::payload_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         frame_byte,
	output logic               last_byte
);
	import ggfb_pkg::*;

	logic [3:0]  pos_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        adv, go, at_end;
	logic [7:0]  cur_byte;

	assign adv    = !out_valid_q || !out_stall;
	assign go     = adv && q_valid;
	assign at_end = (pos_q == POS_CRC_HI);
	assign pop    = go && at_end;

	always_comb begin
		case (pos_q)
			POS_ADDR:     cur_byte = device_address;
			POS_FUNC:     cur_byte = FUNC_WRITE_MULTI;
			POS_REG_HI:   cur_byte = START_REG_HI;
			POS_REG_LO:   cur_byte = START_REG_LO;
			POS_CNT_HI:   cur_byte = 8'h00;
			POS_CNT_LO:   cur_byte = REG_COUNT;
			POS_BCOUNT:   cur_byte = BYTE_COUNT;
			POS_ACTION:   cur_byte = ACTION_GOTO;
			POS_ZERO_A:   cur_byte = 8'h00;
			POS_ZERO_B:   cur_byte = 8'h00;
			POS_POSITION: cur_byte = head.position_byte;
			POS_SPEED:    cur_byte = head.speed_byte;
			POS_FORCE:    cur_byte = head.force_byte;
			POS_CRC_LO:   cur_byte = crc_q[7:0];
			POS_CRC_HI:   cur_byte = crc_q[15:8];
			default:      cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_ADDR;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
			pos_q       <= at_end ? POS_ADDR : pos_q + 4'd1;
			if (pos_q < 4'(CRC_SPAN)) begin
				crc_q <= crc_feed((pos_q == POS_ADDR) ? CRC_INIT : crc_q, cur_byte);
			end
		end else if (adv) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			byte_q <= cur_byte;
			last_q <= at_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) pos_q < 4'(FRAME_LEN))
		else $error("Byte position ran past the frame.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != POS_ADDR) |-> q_valid)
		else $error("Frame in progress without a queued command.");
	assert property (@(posedge clk) disable iff (!arst_n) pop |=> pos_q == POS_ADDR)
		else $error("Sequencer did not restart after the last byte.");
	assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (last_q == $past(at_end)))
		else $error("Last-byte flag out of step with the byte position.");

endmodule

>>> hdl/gripper_goto_frame_builder.sv
// ----------------------------------------------------------------------------
// gripper_goto_frame_builder
// A taken command passes the front-end register, the queue and the byte register.
// Frame bytes leave at one per cycle while out_stall is low, fifteen per command;
// a two-entry queue lets new commands enter while a frame is being sent.
// Reset: device address returns to 9, queue and sequencer are emptied.
// ----------------------------------------------------------------------------
module gripper_goto_frame_builder #(
	parameter int FRAC_BITS = ggfb_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [7:0]                   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ggfb_pkg::FIELD_W-1:0] force_frac,
	input  logic [ggfb_pkg::FIELD_W-1:0] width_frac,
	input  logic [ggfb_pkg::FIELD_W-1:0] speed_frac,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   frame_byte,
	output logic                         last_byte
);
	import ggfb_pkg::*;

	logic [7:0] addr_q;
	logic       push, pop, q_valid, q_full;
	payload_t   push_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			addr_q <= cfg_data;
		end
	end

	ggfb_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.force_frac(force_frac),
		.width_frac(width_frac),
		.speed_frac(speed_frac),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	ggfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_full   (q_full),
		.head     (head)
	);

	ggfb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.device_address(addr_q),
		.q_valid       (q_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.last_byte     (last_byte)
	);

endmodule

>>> tb/gripper_goto_frame_builder_tb.sv
// ----------------------------------------------------------------------------
// gripper_goto_frame_builder_tb
// Drives move commands into the frame builder and checks every frame byte it
// emits against an in-bench model of the 15-byte write-multiple-registers frame
// with its CRC-16. A directed table covers the fraction extremes and the
// saturation cases, then random commands run under several device addresses
// with random gaps, random output stalls and one long output hold.
// ----------------------------------------------------------------------------
module gripper_goto_frame_builder_tb;
	import ggfb_pkg::*;

	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 240;
	localparam int PHASE_CMDS  = 68;
	localparam int NUM_PHASES  = 5;
	localparam int MAX_REPORTS = 10;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	typedef struct packed {
		logic [FIELD_W-1:0] force_v;
		logic [FIELD_W-1:0] width_v;
		logic [FIELD_W-1:0] speed_v;
		logic               known;
		logic [7:0]         pos_b;
		logic [7:0]         spd_b;
		logic [7:0]         frc_b;
	} dir_row_t;

	// Rows marked known carry payload bytes that follow directly from the
	// fractions; the others rely on the model alone.
	localparam dir_row_t DIR_TAB [18] = '{
		'{17'd0,      17'd0,      17'd0,      1'b1, 8'd255, 8'd0,   8'd0},
		'{17'd65536,  17'd65536,  17'd65536,  1'b1, 8'd0,   8'd255, 8'd255},
		'{17'd131071, 17'd131071, 17'd131071, 1'b1, 8'd0,   8'd255, 8'd255},
		'{17'd65537,  17'd65537,  17'd65537,  1'b1, 8'd0,   8'd255, 8'd255},
		'{17'd65535,  17'd65535,  17'd65535,  1'b1, 8'd0,   8'd254, 8'd254},
		'{17'd1,      17'd1,      17'd1,      1'b1, 8'd254, 8'd0,   8'd0},
		'{17'd32768,  17'd32768,  17'd32768,  1'b1, 8'd127, 8'd127, 8'd127},
		'{17'd65536,  17'd0,      17'd0,      1'b1, 8'd255, 8'd0,   8'd255},
		'{17'd0,      17'd65536,  17'd0,      1'b1, 8'd0,   8'd0,   8'd0},
		'{17'd0,      17'd0,      17'd65536,  1'b1, 8'd255, 8'd255, 8'd0},
		'{17'd131071, 17'd0,      17'd0,      1'b1, 8'd255, 8'd0,   8'd255},
		'{17'd0,      17'd131071, 17'd0,      1'b1, 8'd0,   8'd0,   8'd0},
		'{17'd0,      17'd0,      17'd131071, 1'b1, 8'd255, 8'd255, 8'd0},
		'{17'h15555,  17'h0AAAA,  17'h15555,  1'b0, 8'd0,   8'd0,   8'd0},
		'{17'h0AAAA,  17'h15555,  17'h05555,  1'b0, 8'd0,   8'd0,   8'd0},
		'{17'd257,    17'd65279,  17'd12345,  1'b0, 8'd0,   8'd0,   8'd0},
		'{17'd256,    17'd256,    17'd256,    1'b0, 8'd0,   8'd0,   8'd0},
		'{17'd20000,  17'd40000,  17'd60000,  1'b0, 8'd0,   8'd0,   8'd0}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [FIELD_W-1:0] force_frac;
	logic [FIELD_W-1:0] width_frac;
	logic [FIELD_W-1:0] speed_frac;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         frame_byte;
	logic               last_byte;

	frame_byte_t frame_q [$];
	logic [7:0]  model_addr;
	logic        calm;
	logic        hold_req;
	int          errors;
	int          reports;
	int          cmds_sent;
	int          bytes_checked;
	int          cycles;

	gripper_goto_frame_builder #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.force_frac(force_frac),
		.width_frac(width_frac),
		.speed_frac(speed_frac),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_byte(frame_byte),
		.last_byte (last_byte)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [7:0] frac_to_byte(input logic [FIELD_W-1:0] frac,
			input logic invert);
		logic [63:0] one;
		logic [63:0] f;
		logic [63:0] v;
		one = 64'd1 << FRAC;
		f = 64'(frac);
		if (f > one) begin
			f = one;
		end
		if (invert) begin
			f = one - f;
		end
		v = (f * 64'd255) >> FRAC;
		if (v > 64'd255) begin
			v = 64'd255;
		end
		return v[7:0];
	endfunction

	function automatic frame_t assemble_goto_frame(input logic [7:0] addr,
			input logic [7:0] pos_b, input logic [7:0] spd_b, input logic [7:0] frc_b);
		frame_t      fr;
		logic [15:0] crc;
		logic        fbit;
		fr[POS_ADDR]     = addr;
		fr[POS_FUNC]     = FUNC_WRITE_MULTI;
		fr[POS_REG_HI]   = START_REG_HI;
		fr[POS_REG_LO]   = START_REG_LO;
		fr[POS_CNT_HI]   = 8'h00;
		fr[POS_CNT_LO]   = REG_COUNT;
		fr[POS_BCOUNT]   = BYTE_COUNT;
		fr[POS_ACTION]   = ACTION_GOTO;
		fr[POS_ZERO_A]   = 8'h00;
		fr[POS_ZERO_B]   = 8'h00;
		fr[POS_POSITION] = pos_b;
		fr[POS_SPEED]    = spd_b;
		fr[POS_FORCE]    = frc_b;
		crc = CRC_INIT;
		for (int i = 0; i < CRC_SPAN; i++) begin
			for (int j = 0; j < 8; j++) begin
				fbit = crc[0] ^ fr[i][j];
				crc = crc >> 1;
				if (fbit) begin
					crc = crc ^ CRC_POLY;
				end
			end
		end
		fr[POS_CRC_LO] = crc[7:0];
		fr[POS_CRC_HI] = crc[15:8];
		return fr;
	endfunction

	function automatic logic [FIELD_W-1:0] pick_frac();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				return '0;
			end
			1: begin
				return FIELD_W'(1 << FRAC);
			end
			2: begin
				return FIELD_W'((1 << FRAC) - 1);
			end
			3: begin
				return FIELD_W'($urandom_range((1 << FRAC) + 1, (1 << FIELD_W) - 1));
			end
			4, 5: begin
				return FIELD_W'($urandom);
			end
			default: begin
				return FIELD_W'($urandom_range(0, 1 << FRAC));
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic queue_frame(input frame_t fr);
		for (int i = 0; i < FRAME_LEN; i++) begin
			frame_q.push_back({fr[i], i == FRAME_LEN - 1});
		end
	endtask

	task automatic offer_cmd(input logic [FIELD_W-1:0] f, input logic [FIELD_W-1:0] w,
			input logic [FIELD_W-1:0] s, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		force_frac <= f;
		width_frac <= w;
		speed_frac <= s;
		do @(posedge clk); while (in_stall);
		cmds_sent++;
	endtask

	task automatic drain_frames();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_address(input logic [7:0] addr);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= addr;
		do @(posedge clk); while (!cfg_ready);
		model_addr = addr;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Output side: random stalls, plus one long hold on request; each byte taken is checked.
	initial begin
		int          stall_left;
		int          hold_left;
		int          byte_idx;
		int          r;
		frame_byte_t exp_b;
		stall_left = 0;
		hold_left  = 0;
		byte_idx   = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			r = $urandom_range(0, 99);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && r < 25) begin
				stall_left = (r < 22) ? $urandom_range(0, 2) : $urandom_range(7, 29);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (frame_q.size() == 0) begin
					errors++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("Unexpected frame byte %02h (last %0b) with nothing pending",
							frame_byte, last_byte);
					end
				end else begin
					exp_b = frame_q.pop_front();
					bytes_checked++;
					if (frame_byte !== exp_b.data || last_byte !== exp_b.last) begin
						errors++;
						if (reports < MAX_REPORTS) begin
							reports++;
							$display("Frame byte %0d: expected %02h last %0b, got %02h last %0b",
								byte_idx, exp_b.data, exp_b.last, frame_byte, last_byte);
						end
					end
					byte_idx = exp_b.last ? 0 : byte_idx + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still pending", cycles,
				frame_q.size());
			$display("gripper_goto_frame_builder verification failed");
			$finish;
		end
	end

	initial begin
		logic [7:0]         addr;
		logic [FIELD_W-1:0] f;
		logic [FIELD_W-1:0] w;
		logic [FIELD_W-1:0] s;
		frame_t             fr;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		force_frac    = '0;
		width_frac    = '0;
		speed_frac    = '0;
		out_stall     = 1'b0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		errors        = 0;
		reports       = 0;
		cmds_sent     = 0;
		bytes_checked = 0;
		cycles        = 0;
		model_addr    = ADDR_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < $size(DIR_TAB); i++) begin
			offer_cmd(DIR_TAB[i].force_v, DIR_TAB[i].width_v, DIR_TAB[i].speed_v, pick_gap());
			if (DIR_TAB[i].known) begin
				fr = assemble_goto_frame(model_addr, DIR_TAB[i].pos_b, DIR_TAB[i].spd_b,
					DIR_TAB[i].frc_b);
			end else begin
				fr = assemble_goto_frame(model_addr, frac_to_byte(DIR_TAB[i].width_v, 1'b1),
					frac_to_byte(DIR_TAB[i].speed_v, 1'b0),
					frac_to_byte(DIR_TAB[i].force_v, 1'b0));
			end
			queue_frame(fr);
		end
		drain_frames();

		// Addresses outside the Modbus range go into the frame unchanged.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: addr = 8'd1;
				1: addr = 8'd247;
				2: addr = 8'd0;
				3: addr = 8'd255;
				default: addr = 8'($urandom_range(1, 247));
			endcase
			write_address(addr);
			calm = (p == 3);
			if (p == 1) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_CMDS; n++) begin
				f = pick_frac();
				w = pick_frac();
				s = pick_frac();
				offer_cmd(f, w, s, pick_gap());
				queue_frame(assemble_goto_frame(model_addr, frac_to_byte(w, 1'b1),
					frac_to_byte(s, 1'b0), frac_to_byte(f, 1'b0)));
			end
			drain_frames();
		end

		$display("Sent %0d move commands and checked %0d frame bytes over %0d addresses,",
			cmds_sent, bytes_checked, NUM_PHASES + 1);
		$display("with saturated fractions, random stalls and a %0d-cycle output hold.",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("gripper_goto_frame_builder verification clean");
		end else begin
			$display("%0d mismatching or unexpected frame bytes", errors);
			$display("gripper_goto_frame_builder verification failed");
		end
		$finish;
	end

endmodule
